// File: rtl/smpq_pkg.sv
// Types and codes shared by the sorted minimum priority queue.
package smpq_pkg;

   localparam int VALUE_W = 32;
   localparam int MODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 5;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

// File: rtl/smpq_cell.sv
// One storage cell of the sorted queue: holds an entry and trades with its neighbors.
module smpq_cell (
   input  logic                                 clock,
   input  smpq_pkg::cell_ctrl_type              ctrl,
   input  logic                                 held,
   input  logic                                 prev_lt,
   input  logic signed [smpq_pkg::VALUE_W-1:0]  prev_value,
   input  logic signed [smpq_pkg::VALUE_W-1:0]  next_value,
   output logic signed [smpq_pkg::VALUE_W-1:0]  entry,
   output logic                                 lt
);
   import smpq_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   assign entry = entry_ff;
   assign lt = entry_ff < ctrl.value;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (held && lt) begin
               entry_in = entry_ff;
            end else if (prev_lt) begin
               entry_in = ctrl.value;
            end else begin
               entry_in = prev_value;
            end
         end
         CELL_REMOVE: entry_in = next_value;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/sorted_min_priority_queue.sv
// Sorted minimum priority queue: a row of compare-and-shift cells plus control.
// Entries sit in ascending order in a row of DEPTH cells, the smallest in the first cell.
// Every cell compares its entry with the incoming value at once, so an enqueue,
// dequeue or peek is done in the cycle it is taken and one item is taken per cycle; the
// result sits in an output register, and the input stalls only while that
// register holds a result that the output side has stalled. Among equal values
// the newest leaves first. The capacity register (reset 16) limits the held count
// to min(capacity, DEPTH); a capacity of zero makes every enqueue report full.
module sorted_min_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  smpq_pkg::req_type             req,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output smpq_pkg::rsp_type             rsp,
   input  logic                          csr_wr_en,
   input  logic [smpq_pkg::CAP_W-1:0]    csr_wr_data
);
   import smpq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   logic [CAP_W-1:0]          cap_ff;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   cell_ctrl_type             ctrl;
   logic                      accept;
   logic                      full;
   logic signed [VALUE_W-1:0] entry [DEPTH];
   logic                      lt [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign full = (CMPW'(count_ff) >= CMPW'(cap_ff)) || (count_ff == CW'(DEPTH));

   always_comb begin
      count_in = count_ff;
      ctrl.op = CELL_HOLD;
      ctrl.value = req.value;
      rsp_in.value_out = '0;
      rsp_in.status = STATUS_OK;
      case (req.mode)
         MODE_ENQUEUE: begin
            if (full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               ctrl.op = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         MODE_DEQUEUE, MODE_PEEK: begin
            if (count_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.value_out = entry[0];
               if (req.mode == MODE_DEQUEUE) begin
                  ctrl.op = CELL_REMOVE;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      if (!accept) begin
         ctrl.op = CELL_HOLD;
         count_in = count_ff;
      end
      rsp_in.count = COUNT_W'(count_in);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      prev_lt;
      logic signed [VALUE_W-1:0] prev_value;
      logic signed [VALUE_W-1:0] next_value;

      if (i == 0) begin : g_first
         assign prev_lt = 1'b1;
         assign prev_value = req.value;
      end else begin : g_rest
         assign prev_lt = lt[i-1];
         assign prev_value = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_value = entry[i];
      end else begin : g_inner
         assign next_value = entry[i+1];
      end

      smpq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .held       (count_ff > CW'(i)),
         .prev_lt    (prev_lt),
         .prev_value (prev_value),
         .next_value (next_value),
         .entry      (entry[i]),
         .lt         (lt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/smpq_checker.sv
// Port-level checks for the sorted minimum priority queue, bound to the top level.
module smpq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input smpq_pkg::rsp_type    rsp
);
   import smpq_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("transfer without result");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == STATUS_EMPTY |-> rsp.count == '0 && rsp.value_out == '0)
      else $error("empty result with data");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == STATUS_FULL |-> rsp.value_out == '0)
      else $error("full result with data");

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// File: dv/sorted_min_priority_queue_test.sv
// Self-checking testbench for the sorted minimum priority queue: directed and random traffic.
`timescale 1ns / 1ps

module sorted_min_priority_queue_test;
   import smpq_pkg::*;

   localparam int QDEPTH = 16;
   localparam int LONG_HOLD = 120;
   localparam int N_PHASES = 10;
   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;

   typedef struct {
      req_type item;
      bit      known;
      rsp_type want;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp;
   logic              csr_wr_en;
   logic [CAP_W-1:0]  csr_wr_data;

   logic signed [VALUE_W-1:0] held_vals [QDEPTH];
   int                        held_n;
   logic [CAP_W-1:0]          cap_reg;

   rsp_type outcome_fifo [$];
   int      mismatch_n;
   int      sent_n;
   int      checked_n;
   int      full_n;
   int      empty_n;
   int      peak_n;
   int      cap_writes;
   bit      long_hold_due;
   bit      long_hold_on;

   plan_row_type opening_plan [23] = '{
      '{'{MODE_PEEK, 32'h0000_0000}, 1'b1, '{32'h0, STATUS_EMPTY, 5'd0}},
      '{'{MODE_DEQUEUE, 32'hFFFF_FFFF}, 1'b1, '{32'h0, STATUS_EMPTY, 5'd0}},
      '{'{MODE_IDLE, 32'h5A5A_A5A5}, 1'b1, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_ENQUEUE, 32'h7FFF_FFFF}, 1'b1, '{32'h0, STATUS_OK, 5'd1}},
      '{'{MODE_ENQUEUE, 32'h8000_0000}, 1'b1, '{32'h0, STATUS_OK, 5'd2}},
      '{'{MODE_PEEK, 32'h0000_0000}, 1'b1, '{32'h8000_0000, STATUS_OK, 5'd2}},
      '{'{MODE_ENQUEUE, 32'h0000_0000}, 1'b1, '{32'h0, STATUS_OK, 5'd3}},
      '{'{MODE_ENQUEUE, 32'hFFFF_FFFF}, 1'b1, '{32'h0, STATUS_OK, 5'd4}},
      '{'{MODE_ENQUEUE, 32'h0000_0005}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_ENQUEUE, 32'h0000_0005}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_ENQUEUE, 32'h8000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_IDLE, 32'hFFFF_FFFF}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_DEQUEUE, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_DEQUEUE, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_PEEK, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_DEQUEUE, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_DEQUEUE, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_DEQUEUE, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_DEQUEUE, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_DEQUEUE, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK, 5'd0}},
      '{'{MODE_DEQUEUE, 32'h0000_0000}, 1'b1, '{32'h0, STATUS_EMPTY, 5'd0}},
      '{'{MODE_PEEK, 32'h0000_0000}, 1'b1, '{32'h0, STATUS_EMPTY, 5'd0}},
      '{'{MODE_ENQUEUE, 32'h1234_5678}, 1'b0, '{32'h0, STATUS_OK, 5'd0}}
   };

   int cap_plan [N_PHASES] = '{1, 0, 31, 17, 3, 16, 2, 8, 24, 16};
   int enq_plan [N_PHASES] = '{70, 60, 85, 90, 30, 50, 60, 55, 45, 20};

   sorted_min_priority_queue #(
      .DEPTH(QDEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic rsp_type pq_outcome(req_type item);
      rsp_type                   res;
      logic signed [VALUE_W-1:0] v;
      int                        room;
      int                        slot;
      res = '0;
      v = item.value;
      room = (int'(cap_reg) > QDEPTH) ? QDEPTH : int'(cap_reg);
      case (item.mode)
         MODE_ENQUEUE: begin
            if (held_n >= room) begin
               res.status = STATUS_FULL;
            end else begin
               slot = held_n;
               while (slot > 0 && held_vals[slot-1] >= v) begin
                  held_vals[slot] = held_vals[slot-1];
                  slot--;
               end
               held_vals[slot] = v;
               held_n++;
            end
         end
         MODE_DEQUEUE, MODE_PEEK: begin
            if (held_n == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.value_out = held_vals[0];
               if (item.mode == MODE_DEQUEUE) begin
                  for (int k = 1; k < held_n; k++) held_vals[k-1] = held_vals[k];
                  held_n--;
               end
            end
         end
         default: ;
      endcase
      res.count = COUNT_W'(held_n);
      return res;
   endfunction

   function automatic req_type random_item(int enq_pct);
      req_type item;
      int      pick;
      pick = $urandom_range(99, 0);
      if (pick < 4) item.mode = MODE_IDLE;
      else if (pick < 4 + enq_pct) item.mode = MODE_ENQUEUE;
      else if ($urandom_range(3, 0) == 0) item.mode = MODE_PEEK;
      else item.mode = MODE_DEQUEUE;
      case ($urandom_range(7, 0))
         0, 1: item.value = int'($urandom_range(8, 0)) - 4;
         2: item.value = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: item.value = $urandom;
      endcase
      return item;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
      mismatch_n++;
   endtask

   task automatic offer_item(req_type item, bit known, rsp_type want);
      rsp_type calc;
      req <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      calc = pq_outcome(item);
      outcome_fifo.push_back(known ? want : calc);
      sent_n++;
      if (calc.status == STATUS_FULL) full_n++;
      if (calc.status == STATUS_EMPTY) empty_n++;
      if (held_n > peak_n) peak_n = held_n;
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (outcome_fifo.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_wr_data <= cap;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_reg = cap;
      cap_writes++;
   endtask

   task automatic run_phase(int n_items, int enq_pct);
      int burst;
      burst = 0;
      repeat (n_items) begin
         if (burst == 0) begin
            burst = $urandom_range(24, 1);
            idle_cycles(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1));
         end
         offer_item(random_item(enq_pct), 1'b0, '0);
         burst--;
      end
   endtask

   initial begin : rsp_pacer
      int seg;
      int style;
      rsp_stall <= 1'b0;
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            long_hold_on = 1'b1;
            repeat (LONG_HOLD) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
            long_hold_on = 1'b0;
         end else begin
            seg = $urandom_range(80, 10);
            style = $urandom_range(3, 0);
            repeat (seg) begin
               @(posedge clock);
               case (style)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(99, 0) < 30);
                  2: rsp_stall <= ~rsp_stall;
                  default: rsp_stall <= ($urandom_range(99, 0) < 70);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_fifo.size() == 0) begin
            report_mismatch("unexpected transfer", rsp.value_out, 32'h0);
         end else begin
            want = outcome_fifo.pop_front();
            checked_n++;
            if (rsp.value_out !== want.value_out)
               report_mismatch("value_out", rsp.value_out, want.value_out);
            if (rsp.status !== want.status)
               report_mismatch("status", 32'(rsp.status), 32'(want.status));
            if (rsp.count !== want.count)
               report_mismatch("count", 32'(rsp.count), 32'(want.count));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      held_n = 0;
      cap_reg = CAP_RESET;
      mismatch_n = 0;
      sent_n = 0;
      checked_n = 0;
      full_n = 0;
      empty_n = 0;
      peak_n = 0;
      cap_writes = 0;
      long_hold_due = 1'b0;
      long_hold_on = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[r])
         offer_item(opening_plan[r].item, opening_plan[r].known, opening_plan[r].want);

      cap_plan[7] = $urandom_range(31, 0);
      cap_plan[8] = $urandom_range(31, 0);
      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         write_capacity(CAP_W'(cap_plan[p]));
         if (p == 3) begin
            run_phase(40, enq_plan[p]);
            req_valid <= 1'b0;
            long_hold_due = 1'b1;
            wait (long_hold_on);
            @(posedge clock);
            run_phase(30, enq_plan[p]);
            run_phase(40, enq_plan[p]);
         end else if (p == 5) begin
            run_phase(40, enq_plan[p]);
            settle();
            run_phase(40, enq_plan[p]);
         end else begin
            run_phase(80, enq_plan[p]);
         end
      end
      settle();
      repeat (5) @(posedge clock);

      $display("Sent %0d transfers, checked %0d results (%0d full, %0d empty), peak depth %0d.",
               sent_n, checked_n, full_n, empty_n, peak_n);
      $display("Wrote the capacity %0d times, from zero up to the top of the 5-bit range.",
               cap_writes);
      if (mismatch_n == 0 && outcome_fifo.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue.sv
rtl/smpq_checker.sv
dv/sorted_min_priority_queue_test.sv
